FILE: rtl/cti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cti_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CFG_W      = 7;
    localparam int FREQ_W     = 32;
    localparam int LEVEL_W    = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;
    localparam int DIVD_W     = FREQ_W + LEVEL_W;
    localparam int QUOT_W     = LEVEL_W;
    localparam int PROD_W     = DIVD_W + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [1:0]                pad;
        logic [FREQ_W-1:0]         query_freq;
        logic signed [LEVEL_W-1:0] point_level;
        logic [FREQ_W-1:0]         point_freq;
        logic [5:0]                point_index;
    } in_data_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SEARCH,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/cti_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cti_div
    import cti_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [FREQ_W-1:0] divisor,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient
);

    localparam int COUNT_W = $clog2(QUOT_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FREQ_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]  quo_reg, quo_next;
    logic [FREQ_W-1:0]  dsr_reg, dsr_next;
    logic [FREQ_W:0]    trial;
    logic [FREQ_W:0]    diff;
    logic               ge;

    // The caller guarantees dividend < divisor * 2**QUOT_W, so the upper
    // part starts below the divisor and the quotient fits in QUOT_W bits.
    always_comb begin
        trial      = {rem_reg, quo_reg[QUOT_W-1]};
        ge         = trial >= {1'b0, dsr_reg};
        diff       = trial - {1'b0, dsr_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = COUNT_W'(QUOT_W - 1);
            rem_next   = dividend[DIVD_W-1:QUOT_W];
            quo_next   = dividend[QUOT_W-1:0];
            dsr_next   = divisor;
        end else if (busy_reg) begin
            rem_next   = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            quo_next   = {quo_reg[QUOT_W-2:0], ge};
            count_next = count_reg - COUNT_W'(1);
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/calibration_table_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Contents
// s_        in         s_tvalid/s_tready  write point or query
// m_        out        m_tvalid/m_tready  interpolated level, empty flag
// cfg_      in         cfg_wr_en          points_in_use
//
// A write item leaves s_tready high; a query keeps s_tready low through its steps:
// only the output load on an empty table, one or two end-point reads and the output
// load when it clamps to the first or last point, and when it interpolates two end-point
// reads, up to six search reads, a multiply, a divider start, 16 quotient bits and the output load.
// A result still waiting on m_tready keeps the next query in its output-load cycle.
// Reset is synchronous and active low; the table is not cleared.

module calibration_table_interpolator
    import cti_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // point_index, point_freq, point_level, query_freq, two unused pad bits
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // level
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // table_empty
    output logic                       m_tuser
);

    localparam int WORD_W = FREQ_W + LEVEL_W;

    in_data_t              in_d;
    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      points_reg;
    logic [CFG_W-1:0]      n_used;
    logic [WORD_W-1:0]     mem [MAX_POINTS];
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data_reg;
    logic [FREQ_W-1:0]     rd_freq;
    logic [LEVEL_W-1:0]    rd_level;
    logic                  s_accept;

    logic [FREQ_W-1:0]     q_reg, q_next;
    logic [IDX_W-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [IDX_W:0]        mid_sum;
    logic [FREQ_W-1:0]     flo_reg, flo_next, fhi_reg, fhi_next, df_reg, df_next;
    logic [LEVEL_W-1:0]    vlo_reg, vlo_next, vhi_reg, vhi_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [LEVEL_W-1:0]    res_level_reg, res_level_next;
    logic                  res_empty_reg, res_empty_next;
    logic                  m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]    m_level_reg, m_level_next;
    logic                  m_empty_reg, m_empty_next;

    logic [FREQ_W-1:0]     dq;
    logic signed [LEVEL_W:0] dv;
    logic signed [PROD_W:0]  prod_full;
    logic [PROD_W-1:0]     prod_mag;
    logic [LEVEL_W:0]      quot_signed;
    logic [LEVEL_W:0]      level_sum;
    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;

    assign in_d     = in_data_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign n_used   = (points_reg > CFG_W'(MAX_POINTS)) ? CFG_W'(MAX_POINTS) : points_reg;
    assign rd_freq  = rd_data_reg[WORD_W-1:LEVEL_W];
    assign rd_level = rd_data_reg[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= '0;
        end else if (cfg_wr_en) begin
            points_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == OP_WRITE) begin
            mem[in_d.point_index[IDX_W-1:0]] <= {in_d.point_freq, in_d.point_level};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign dq          = q_reg - flo_reg;
    assign dv          = $signed({vhi_reg[LEVEL_W-1], vhi_reg})
                       - $signed({vlo_reg[LEVEL_W-1], vlo_reg});
    assign prod_full   = $signed({1'b0, dq}) * dv;
    assign prod_mag    = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign quot_signed = prod_reg[PROD_W-1] ? (LEVEL_W+1)'(-{1'b0, div_quot})
                                            : {1'b0, div_quot};
    assign level_sum   = {vlo_reg[LEVEL_W-1], vlo_reg} + quot_signed;
    assign div_start   = (state_reg == ST_DIV_GO);

    cti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_mag[DIVD_W-1:0]),
        .divisor  (df_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next     = state_reg;
        rd_addr        = '0;
        q_next         = q_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        flo_next       = flo_reg;
        fhi_next       = fhi_reg;
        vlo_next       = vlo_reg;
        vhi_next       = vhi_reg;
        df_next        = df_reg;
        prod_next      = prod_reg;
        res_level_next = res_level_reg;
        res_empty_next = res_empty_reg;
        mid_sum        = '0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_level_next   = m_level_reg;
        m_empty_next   = m_empty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == OP_QUERY) begin
                    q_next  = in_d.query_freq;
                    hi_next = IDX_W'(n_used - CFG_W'(1));
                    if (n_used == '0) begin
                        res_level_next = '0;
                        res_empty_next = 1'b1;
                        state_next     = ST_RESULT;
                    end else begin
                        res_empty_next = 1'b0;
                        state_next     = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                if (q_reg <= rd_freq) begin
                    res_level_next = rd_level;
                    state_next     = ST_RESULT;
                end else begin
                    flo_next   = rd_freq;
                    vlo_next   = rd_level;
                    lo_next    = '0;
                    rd_addr    = hi_reg;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (q_reg >= rd_freq) begin
                    res_level_next = rd_level;
                    state_next     = ST_RESULT;
                end else begin
                    fhi_next = rd_freq;
                    vhi_next = rd_level;
                    if (hi_reg - lo_reg > IDX_W'(1)) begin
                        mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
                        rd_addr    = mid_sum[IDX_W:1];
                        mid_next   = rd_addr;
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SEARCH: begin
                if (rd_freq <= q_reg) begin
                    lo_next  = mid_reg;
                    flo_next = rd_freq;
                    vlo_next = rd_level;
                end else begin
                    hi_next  = mid_reg;
                    fhi_next = rd_freq;
                    vhi_next = rd_level;
                end
                if (hi_next - lo_next > IDX_W'(1)) begin
                    mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
                    rd_addr  = mid_sum[IDX_W:1];
                    mid_next = rd_addr;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (fhi_reg <= flo_reg) begin
                    res_level_next = vlo_reg;
                    state_next     = ST_RESULT;
                end else begin
                    prod_next  = prod_full[PROD_W-1:0];
                    df_next    = fhi_reg - flo_reg;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    res_level_next = level_sum[LEVEL_W-1:0];
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_level_next = res_level_reg;
                    m_empty_next = res_empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg         <= q_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        flo_reg       <= flo_next;
        fhi_reg       <= fhi_next;
        vlo_reg       <= vlo_next;
        vhi_reg       <= vhi_next;
        df_reg        <= df_next;
        prod_reg      <= prod_next;
        res_level_reg <= res_level_next;
        res_empty_reg <= res_empty_next;
        m_level_reg   <= m_level_next;
        m_empty_reg   <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_level_reg;
    assign m_tuser  = m_empty_reg;

endmodule

`default_nettype wire

FILE: rtl/cti_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cti_checker
    import cti_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_wr_en,
    input wire logic [CFG_W-1:0]      cfg_wr_data,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty table always reports level zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty flag with nonzero level");

    // A query keeps the block busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
        else $error("ready right after a query");

    // A table write leaves the block ready in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_WRITE |=> s_tready)
        else $error("not ready after a write");

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (.*);

`default_nettype wire

FILE: tb/sv/cal_level_checker.sv
`timescale 1ns / 1ps

module cal_level_checker
    import cti_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  m_tuser,
    output int                         error_count,
    output int                         pending_count,
    output int                         checked_count,
    output int                         interp_count
);

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      empty;
        logic                      interp;
    } level_result_t;

    logic [FREQ_W-1:0]         cal_freq [MAX_POINTS];
    logic signed [LEVEL_W-1:0] cal_level [MAX_POINTS];
    logic [CFG_W-1:0]          points_cfg = '0;
    level_result_t             expected_levels [$];
    int                        errors = 0;
    int                        checked = 0;
    int                        interps = 0;

    function automatic level_result_t predict_level(input logic [FREQ_W-1:0] q);
        level_result_t r;
        int            n;
        int            lo;
        int            hi;
        int            mid;
        longint        dq;
        longint        dv;
        longint        df;
        longint        v;
        r = '0;
        n = (points_cfg > MAX_POINTS) ? MAX_POINTS : int'(points_cfg);
        if (n == 0) begin
            r.empty = 1'b1;
            return r;
        end
        lo = 0;
        hi = n - 1;
        if (q <= cal_freq[0]) begin
            r.level = cal_level[0];
            return r;
        end
        if (q >= cal_freq[hi]) begin
            r.level = cal_level[hi];
            return r;
        end
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (cal_freq[mid] <= q) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        if (cal_freq[hi] <= cal_freq[lo]) begin
            r.level = cal_level[lo];
            return r;
        end
        dq = longint'({32'd0, q}) - longint'({32'd0, cal_freq[lo]});
        df = longint'({32'd0, cal_freq[hi]}) - longint'({32'd0, cal_freq[lo]});
        dv = longint'(cal_level[hi]) - longint'(cal_level[lo]);
        v = longint'(cal_level[lo]) + (dq * dv) / df;
        r.level = v[LEVEL_W-1:0];
        r.interp = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        in_data_t      item;
        level_result_t want;
        if (!aresetn) begin
            points_cfg = '0;
            expected_levels.delete();
        end else begin
            if (cfg_wr_en) begin
                points_cfg = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%t: result with no query waiting: expected none, actual level %0d empty %0b",
                             $time, $signed(m_tdata), m_tuser);
                end else begin
                    want = expected_levels.pop_front();
                    checked++;
                    if (m_tdata !== want.level) begin
                        errors++;
                        $display("%t: level mismatch: expected %0d, actual %0d",
                                 $time, want.level, $signed(m_tdata));
                    end
                    if (m_tuser !== want.empty) begin
                        errors++;
                        $display("%t: table_empty mismatch: expected %0b, actual %0b",
                                 $time, want.empty, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item = s_tdata;
                if (s_tuser == OP_WRITE) begin
                    cal_freq[item.point_index] = item.point_freq;
                    cal_level[item.point_index] = item.point_level;
                end else begin
                    want = predict_level(item.query_freq);
                    if (want.interp) begin
                        interps++;
                    end
                    expected_levels.push_back(want);
                end
            end
        end
        error_count <= errors;
        pending_count <= expected_levels.size();
        checked_count <= checked;
        interp_count <= interps;
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cti_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = OP_WRITE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int   error_count;
    int   pending_count;
    int   checked_count;
    int   interp_count;
    logic no_idle = 1'b0;
    int   writes_sent = 0;
    int   queries_sent = 0;
    int   settings_used = 0;
    int   stall_cycles = 0;
    int   plan_points = 0;

    logic [FREQ_W-1:0] plan_freq [MAX_POINTS];

    calibration_table_interpolator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    cal_level_checker level_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .interp_count  (interp_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%t: no item moved for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [5:0] idx, input logic [31:0] f,
                             input logic signed [15:0] lvl, input logic [31:0] q);
        in_data_t d;
        d = '0;
        d.point_index = idx;
        d.point_freq = f;
        d.point_level = lvl;
        d.query_freq = q;
        while (!no_idle && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_QUERY) begin
            queries_sent++;
        end else begin
            writes_sent++;
        end
    endtask

    task automatic write_point(input int idx, input logic [31:0] f, input logic signed [15:0] lvl);
        plan_freq[idx] = f;
        send_item(OP_WRITE, 6'(idx), f, lvl, $urandom());
    endtask

    task automatic query_level(input logic [31:0] q);
        send_item(OP_QUERY, 6'($urandom()), $urandom(), 16'($urandom()), q);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_points(input int n);
        drain();
        cfg_wr_data <= CFG_W'(n);
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        plan_points = (n > MAX_POINTS) ? MAX_POINTS : n;
        settings_used++;
    endtask

    task automatic run_phase(input int n);
        longint                f;
        longint                step_max;
        logic signed [15:0]    lvl;
        logic [31:0]           q;
        int                    eff;
        int                    freq_mode;
        int                    smooth;
        int                    i;
        int                    pick;
        set_points(n);
        eff = plan_points;
        freq_mode = $urandom_range(0, 3);
        smooth = $urandom_range(0, 1);
        case (freq_mode)
            0: f = $urandom_range(0, 1000);
            1, 2: f = {32'd0, $urandom()};
            default: f = 64'hFFFF_FFFF - $urandom_range(0, 4000);
        endcase
        if (freq_mode == 1) begin
            step_max = 16;
        end else begin
            step_max = (64'hFFFF_FFFF - f) / ((eff > 0) ? eff : 1);
        end
        lvl = 16'($urandom());
        for (i = 0; i < eff; i++) begin
            write_point(i, f[31:0], lvl);
            f = f + ({32'd0, $urandom()} % (step_max + 1));
            if (f > 64'hFFFF_FFFF) begin
                f = 64'hFFFF_FFFF;
            end
            if (smooth != 0) begin
                lvl = lvl + 16'($urandom_range(0, 1023)) - 16'sd512;
            end else begin
                lvl = 16'($urandom());
            end
        end
        repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                write_point($urandom_range(0, MAX_POINTS - 1), $urandom(), 16'($urandom()));
            end else begin
                if (eff == 0 || pick < 30) begin
                    q = $urandom();
                end else if (pick < 40) begin
                    q = plan_freq[$urandom_range(0, eff - 1)];
                end else if (pick < 50) begin
                    if (pick[0]) begin
                        q = $urandom_range(0, plan_freq[0]);
                    end else begin
                        q = $urandom_range(plan_freq[eff - 1], 32'hFFFF_FFFF);
                    end
                end else if (eff < 2) begin
                    q = plan_freq[0];
                end else begin
                    i = $urandom_range(0, eff - 2);
                    q = $urandom_range(plan_freq[i], plan_freq[i + 1]);
                end
                query_level(q);
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The table starts out empty, so every query must flag it.
        query_level(32'd0);
        query_level(32'hFFFF_FFFF);
        write_point(0, 32'd1000, 16'sh7FFF);
        query_level(32'd1000);

        set_points(1);
        query_level(32'd0);
        query_level(32'hFFFF_FFFF);

        set_points(2);
        write_point(0, 32'd0, -16'sd32768);
        write_point(1, 32'hFFFF_FFFF, 16'sh7FFF);
        query_level(32'd1);
        query_level(32'h7FFF_FFFF);
        query_level(32'hFFFF_FFFE);
        query_level(32'd0);
        query_level(32'hFFFF_FFFF);
        write_point(0, 32'd0, 16'sh7FFF);
        write_point(1, 32'hFFFF_FFFF, -16'sd32768);
        query_level(32'd1);
        query_level(32'h8000_0000);

        // An unsorted table still has to follow the search deterministically.
        set_points(3);
        write_point(0, 32'd100, 16'sd256);
        write_point(1, 32'd50, -16'sd256);
        write_point(2, 32'd200, 16'sd512);
        query_level(32'd150);
        query_level(32'd120);
        query_level(32'd75);

        phase = 0;
        while (writes_sent + queries_sent < ITEM_TARGET) begin
            case (phase)
                0: n = MAX_POINTS;
                1: n = 127;
                2: n = 1;
                3: n = 0;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        n = $urandom_range(2, 12);
                    end else if (pick < 7) begin
                        n = $urandom_range(13, MAX_POINTS);
                    end else if (pick < 8) begin
                        n = $urandom_range(MAX_POINTS + 1, 127);
                    end else if (pick < 9) begin
                        n = 1;
                    end else begin
                        n = 0;
                    end
                end
            endcase
            if (phase == 5) begin
                no_idle <= 1'b1;
            end else if (phase == 8) begin
                no_idle <= 1'b0;
            end
            run_phase(n);
            phase++;
        end
        drain();

        $display("Run covered %0d items (%0d point writes, %0d queries) over %0d table settings.",
                 writes_sent + queries_sent, writes_sent, queries_sent, settings_used);
        $display("%0d results checked, %0d interpolated between two points, %0d mismatches.",
                 checked_count, interp_count, error_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cti_pkg.sv
rtl/cti_div.sv
rtl/calibration_table_interpolator.sv
rtl/cti_checker.sv
tb/sv/cal_level_checker.sv
tb/sv/testbench.sv
